// ----- sv/ppt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants for the peer presence table.
// ----------------------------------------------------------------------------
package ppt_pkg;

	localparam int ID_W     = 8;
	localparam int TIME_W   = 32;
	localparam int WORD_W   = ID_W + TIME_W;
	localparam int SEEN_W   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [TIME_W-1:0] EXPIRE_RESET   = 32'd15000;
	localparam logic [TIME_W-1:0] WINDOW_RESET   = 32'd10000;
	localparam logic [SEEN_W-1:0] MIN_SEEN_RESET = 4'd2;
	localparam logic [SEEN_W-1:0] SEEN_MAX       = 4'd15;

	localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEEN = 2'd2;

	localparam logic REQ_HEARTBEAT = 1'b0;
	localparam logic REQ_SWEEP     = 1'b1;

	typedef enum logic [2:0] {
		STAT_REFRESHED = 3'd0,
		STAT_INSERTED  = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_ZERO_ID   = 3'd3,
		STAT_SWEEP     = 3'd4
	} status_t;

	typedef struct packed {
		logic              req_type;
		logic [ID_W-1:0]   peer_id;
		logic [TIME_W-1:0] now_time;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [SEEN_W-1:0] seen_count;
		logic              group_present;
	} rsp_t;

	typedef struct packed {
		logic [TIME_W-1:0] expire_time;
		logic [TIME_W-1:0] window_time;
		logic [SEEN_W-1:0] min_seen;
	} cfg_t;

endpackage

// ----- sv/ppt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ppt_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 12
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- sv/ppt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_ctrl
// Table walker: reads entries one per cycle, evaluates, writes back.
// ----------------------------------------------------------------------------
module ppt_ctrl #(
	parameter int TABLE_ENTRIES = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire ppt_pkg::req_t req,
	input  wire ppt_pkg::cfg_t cfg,
	output logic               busy,
	output logic               done,
	output ppt_pkg::rsp_t      rsp
);

	localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW   = $clog2(TABLE_ENTRIES + 1);
	localparam int CMPW = (CW > ppt_pkg::SEEN_W) ? CW : ppt_pkg::SEEN_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t                      state_q;
	ppt_pkg::req_t               req_q;
	logic [IW-1:0]               rd_idx_q;
	logic                        rd_act_q;
	logic                        vld_s1;
	logic [IW-1:0]               idx_s1;
	logic [TABLE_ENTRIES-1:0]    valid_q;
	logic                        free_found_q;
	logic [IW-1:0]               free_idx_q;
	logic [CW-1:0]               cnt_q;
	logic                        done_q;
	ppt_pkg::rsp_t               rsp_q;

	logic                        accept;
	logic [ppt_pkg::WORD_W-1:0]  rd_word;
	logic [ppt_pkg::ID_W-1:0]    rd_id;
	logic [ppt_pkg::TIME_W-1:0]  rd_time;
	logic [ppt_pkg::TIME_W-1:0]  age;
	logic                        occ;
	logic                        hit;
	logic                        expired;
	logic                        recent;
	logic                        last;
	logic                        free_now;
	logic [IW-1:0]               free_sel;
	logic                        finish;
	logic                        we;
	logic [IW-1:0]               waddr;
	logic [ppt_pkg::WORD_W-1:0]  wdata;
	logic [2:0]                  fin_status;
	logic [CW-1:0]               cnt_next;
	logic [CMPW-1:0]             cnt_ext;
	logic [CMPW-1:0]             min_ext;
	logic                        is_sweep;

	assign accept   = start && (state_q == S_IDLE);
	assign is_sweep = (req_q.req_type == ppt_pkg::REQ_SWEEP);
	assign rd_id    = rd_word[ppt_pkg::WORD_W-1 -: ppt_pkg::ID_W];
	assign rd_time  = rd_word[ppt_pkg::TIME_W-1:0];

	ppt_ram #(
		.WIDTH(ppt_pkg::WORD_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_act_q),
		.raddr(rd_idx_q),
		.rdata(rd_word)
	);

	// evaluate the entry returned by the read issued last cycle
	always_comb begin
		occ      = vld_s1 && valid_q[idx_s1] && (rd_id != '0);
		age      = req_q.now_time - rd_time;
		hit      = occ && !is_sweep && (rd_id == req_q.peer_id);
		expired  = occ && is_sweep && (age > cfg.expire_time);
		recent   = occ && is_sweep && !expired && (age <= cfg.window_time);
		last     = vld_s1 && (idx_s1 == LAST_IDX);
		free_now = free_found_q || (vld_s1 && !occ);
		free_sel = free_found_q ? free_idx_q : idx_s1;
		cnt_next = cnt_q + CW'(recent);
		finish   = hit || last;
		we       = 1'b0;
		waddr    = idx_s1;
		wdata    = {rd_id, req_q.now_time};
		if (is_sweep) begin
			fin_status = ppt_pkg::STAT_SWEEP;
		end else if (hit) begin
			fin_status = ppt_pkg::STAT_REFRESHED;
		end else if (free_now) begin
			fin_status = ppt_pkg::STAT_INSERTED;
		end else begin
			fin_status = ppt_pkg::STAT_FULL;
		end
		if (hit) begin
			we = 1'b1;
		end else if (expired) begin
			we    = 1'b1;
			wdata = '0;
		end else if (last && !is_sweep && free_now) begin
			we    = 1'b1;
			waddr = free_sel;
			wdata = {req_q.peer_id, req_q.now_time};
		end
		cnt_ext = CMPW'(cnt_next);
		min_ext = CMPW'(cfg.min_seen);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rd_act_q     <= 1'b0;
			vld_s1       <= 1'b0;
			valid_q      <= '0;
			done_q       <= 1'b0;
			free_found_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			done_q <= 1'b0;
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.req_type == ppt_pkg::REQ_HEARTBEAT && req.peer_id == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q  <= S_SCAN;
							rd_act_q <= 1'b1;
						end
						free_found_q <= 1'b0;
						cnt_q        <= '0;
					end
				end
				S_SCAN: begin
					vld_s1 <= rd_act_q;
					if (rd_act_q && rd_idx_q == LAST_IDX) begin
						rd_act_q <= 1'b0;
					end
					if (vld_s1 && !occ && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					cnt_q <= cnt_next;
					if (finish) begin
						state_q  <= S_IDLE;
						rd_act_q <= 1'b0;
						vld_s1   <= 1'b0;
						done_q   <= 1'b1;
					end
				end
				default: begin
					state_q  <= S_IDLE;
					rd_act_q <= 1'b0;
					vld_s1   <= 1'b0;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req;
			rd_idx_q <= '0;
			rsp_q    <= '{status: ppt_pkg::STAT_ZERO_ID, seen_count: '0, group_present: 1'b0};
		end else if (state_q == S_SCAN) begin
			if (rd_act_q && rd_idx_q != LAST_IDX) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			idx_s1 <= rd_idx_q;
			if (vld_s1 && !occ && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (finish) begin
				rsp_q.status <= fin_status;
				if (is_sweep) begin
					rsp_q.seen_count    <= (cnt_ext > CMPW'(ppt_pkg::SEEN_MAX)) ?
						ppt_pkg::SEEN_MAX : cnt_ext[ppt_pkg::SEEN_W-1:0];
					rsp_q.group_present <= (cnt_ext >= min_ext);
				end else begin
					rsp_q.seen_count    <= '0;
					rsp_q.group_present <= 1'b0;
				end
			end
		end
	end

	assign busy = (state_q == S_SCAN);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

// ----- sv/peer_presence_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// peer_presence_table
// Neighbor table with aging: heartbeat refresh/insert, sweep with eviction
// and recent-peer count.
// ----------------------------------------------------------------------------
// A transfer is taken when start is high and busy is low. Each request yields
// exactly one result, shown on rsp for a single cycle while done is high; the
// receiver cannot stall it, so it must capture rsp whenever done is set.
// Entries live in one RAM (id and timestamp per word) walked one entry per
// cycle through its single read port, so a sweep, or a heartbeat that finds
// no match, walks the whole table before the next start can be taken. A
// heartbeat that matches an entry finishes at that entry; a heartbeat from
// id zero is answered the next cycle and leaves the table untouched. After
// reset the table is empty at once: a per-entry valid flop masks words never
// written. Config registers are written through cfg_we/cfg_idx/cfg_wdata;
// the user must do so only while the block is idle, which the block itself
// does not enforce; an index beyond min_seen is ignored.
// ----------------------------------------------------------------------------
module peer_presence_table #(
	parameter int TABLE_ENTRIES = 12
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// request channel
	input  wire logic                               start,
	input  wire ppt_pkg::req_t                      req,
	output logic                                    busy,
	// result channel
	output logic                                    done,
	output ppt_pkg::rsp_t                           rsp,
	// config write port
	input  wire logic                               cfg_we,
	input  wire logic [ppt_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [ppt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	ppt_pkg::cfg_t cfg_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expire_time <= ppt_pkg::EXPIRE_RESET;
			cfg_q.window_time <= ppt_pkg::WINDOW_RESET;
			cfg_q.min_seen    <= ppt_pkg::MIN_SEEN_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				ppt_pkg::CFG_EXPIRE:   cfg_q.expire_time <= cfg_wdata;
				ppt_pkg::CFG_WINDOW:   cfg_q.window_time <= cfg_wdata;
				ppt_pkg::CFG_MIN_SEEN: cfg_q.min_seen    <= cfg_wdata[ppt_pkg::SEEN_W-1:0];
				default: ;
			endcase
		end
	end

	// table walker with the entry RAM
	ppt_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.cfg   (cfg_q),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	// a result never appears while a walk is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// id zero heartbeat is answered in the next cycle
	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type == ppt_pkg::REQ_HEARTBEAT && req.peer_id == '0)
		|=> (done && rsp.status == ppt_pkg::STAT_ZERO_ID))
		else $error("id zero heartbeat not answered at once");

	// heartbeat results carry no count
	a_hb_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ppt_pkg::STAT_SWEEP)
		|-> (rsp.seen_count == '0 && !rsp.group_present))
		else $error("heartbeat result with count");

	// a walk ends with exactly one strobe
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(busy) && done)
		else $error("walk ended without result");

endmodule
`default_nettype wire

// ----- test/ppt_table_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_table_check
// Tracks the peer table from the request and config traffic and checks every
// result transfer against the predicted status, seen count and group flag.
// ----------------------------------------------------------------------------
module ppt_table_check
	import ppt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire req_t                  req,
	input  wire logic                  done,
	input  wire rsp_t                  rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                         mismatches,
	output int                         checked,
	output int                         outstanding,
	output int                         drops
);

	logic [ID_W-1:0]   peer_ids [TABLE_ENTRIES];
	logic [TIME_W-1:0] last_seen[TABLE_ENTRIES];
	logic [TIME_W-1:0] expire_ms;
	logic [TIME_W-1:0] window_ms;
	logic [SEEN_W-1:0] min_peers;
	rsp_t              awaited_rsp[$];
	rsp_t              want;

	// Applies one request to the tracked table and returns the result it owes.
	function automatic rsp_t apply_request(input req_t r);
		rsp_t              res;
		logic [TIME_W-1:0] age;
		int                tally;
		int                slot;
		res   = '0;
		slot  = -1;
		tally = 0;
		if (r.req_type == REQ_HEARTBEAT) begin
			if (r.peer_id == '0) begin
				res.status = STAT_ZERO_ID;
			end else begin
				for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++)
					if (peer_ids[i] == r.peer_id) slot = i;
				if (slot >= 0) begin
					last_seen[slot] = r.now_time;
					res.status = STAT_REFRESHED;
				end else begin
					for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++)
						if (peer_ids[i] == '0) slot = i;
					if (slot >= 0) begin
						peer_ids[slot]  = r.peer_id;
						last_seen[slot] = r.now_time;
						res.status = STAT_INSERTED;
					end else begin
						res.status = STAT_FULL;
						drops++;
					end
				end
			end
		end else begin
			// evict first, then count what is left; ages wrap mod 2^32
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				age = r.now_time - last_seen[i];
				if (peer_ids[i] != '0 && age > expire_ms) begin
					peer_ids[i]  = '0;
					last_seen[i] = '0;
				end
			end
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				age = r.now_time - last_seen[i];
				if (peer_ids[i] != '0 && age <= window_ms) tally++;
			end
			res.status        = STAT_SWEEP;
			res.seen_count    = (tally > SEEN_MAX) ? SEEN_MAX : SEEN_W'(tally);
			res.group_present = (tally >= min_peers);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				peer_ids[i]  = '0;
				last_seen[i] = '0;
			end
			expire_ms   = EXPIRE_RESET;
			window_ms   = WINDOW_RESET;
			min_peers   = MIN_SEEN_RESET;
			awaited_rsp.delete();
			mismatches  = 0;
			checked     = 0;
			outstanding = 0;
			drops       = 0;
		end else begin
			// a result leaving now belongs to an earlier request
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected result: status %0d count %0d group %0b",
						$time, rsp.status, rsp.seen_count, rsp.group_present);
				end else begin
					want = awaited_rsp.pop_front();
					checked++;
					if (rsp.status !== want.status || rsp.seen_count !== want.seen_count ||
						rsp.group_present !== want.group_present) begin
						mismatches++;
						$display("%0t ns: mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
							$time, want.status, want.seen_count, want.group_present,
							rsp.status, rsp.seen_count, rsp.group_present);
					end
				end
			end
			if (start && !busy)
				awaited_rsp.push_back(apply_request(req));
			if (cfg_we) begin
				case (cfg_idx)
					CFG_EXPIRE:   expire_ms = cfg_wdata;
					CFG_WINDOW:   window_ms = cfg_wdata;
					CFG_MIN_SEEN: min_peers = cfg_wdata[SEEN_W-1:0];
					default:      ;
				endcase
			end
			outstanding = awaited_rsp.size();
		end
	end

endmodule

// ----- test/tb_peer_presence_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peer_presence_table
// Drives heartbeat and sweep requests plus config writes into the peer table;
// a side checker predicts and compares every result, this top gives verdict.
// ----------------------------------------------------------------------------
module tb_peer_presence_table;
	import ppt_pkg::*;

	localparam int TABLE_ENTRIES = 12;
	localparam int TIMEOUT_NS    = 5_000_000;
	// register index past min_seen; the block must ignore writes to it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	req_t                  req;
	logic                  done;
	rsp_t                  rsp;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int mismatches;
	int checked;
	int outstanding;
	int drops;
	int sent;
	int sweeps;
	int settings;

	peer_presence_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	ppt_table_check #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) table_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.checked(checked),
		.outstanding(outstanding),
		.drops(drops)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case a transfer never completes
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout: %0d results still owed", outstanding);
		$display("Regression FAIL");
		$finish;
	end

	function automatic req_t make_req(input logic kind, input logic [ID_W-1:0] id,
		input logic [TIME_W-1:0] stamp);
		req_t r;
		r.req_type = kind;
		r.peer_id  = id;
		r.now_time = stamp;
		return r;
	endfunction

	// Called at a falling edge. Holds start high until the block takes the
	// transfer, then returns at the next falling edge with start still high,
	// so back-to-back requests never drop start in between.
	task automatic issue(input req_t item);
		start <= 1'b1;
		req   <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
		if (item.req_type == REQ_SWEEP) sweeps++;
		@(negedge clk);
	endtask

	// One register write per cycle; the caller lowers cfg_we afterwards.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	// Wait for every owed result and for the table walk to finish, then a
	// few spare cycles before touching the registers.
	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0 || busy) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One table setting followed by a run of random traffic. Most requests
	// are heartbeats from a small roster of peers (more peers than slots, so
	// the table fills), a quarter are sweeps on a slowly advancing clock, and
	// the rest is noise: id zero and stray peers with arbitrary stamps.
	task automatic run_phase(input logic [TIME_W-1:0] expire, input logic [TIME_W-1:0] window,
		input logic [SEEN_W-1:0] min_cnt, input logic [TIME_W-1:0] step_max,
		input logic [TIME_W-1:0] base, input int count, input bit poke_unused);
		logic [ID_W-1:0]   roster[16];
		logic [TIME_W-1:0] clock_ms;
		req_t              item;
		int                pick;
		int                burst;
		int                gap;
		settle();
		set_reg(CFG_EXPIRE, expire);
		set_reg(CFG_WINDOW, window);
		// upper data bits are don't-care for the 4-bit minimum
		set_reg(CFG_MIN_SEEN, ($urandom() & 32'hFFFF_FFF0) | min_cnt);
		if (poke_unused) set_reg(CFG_UNUSED, $urandom());
		cfg_we <= 1'b0;
		settings++;
		foreach (roster[i]) roster[i] = ID_W'($urandom_range(1, 255));
		clock_ms = base;
		burst    = 0;
		for (int n = 0; n < count; n++) begin
			clock_ms += $urandom_range(0, step_max);
			pick = $urandom_range(0, 99);
			if (pick < 25)
				item = make_req(REQ_SWEEP, ID_W'($urandom_range(0, 255)), clock_ms);
			else if (pick < 30)
				item = make_req(REQ_HEARTBEAT, '0, clock_ms);
			else if (pick < 35)
				item = make_req(REQ_HEARTBEAT, ID_W'($urandom_range(1, 255)), $urandom());
			else
				item = make_req(REQ_HEARTBEAT, roster[$urandom_range(0, 15)], clock_ms);
			// bursts of back-to-back requests, mostly separated by idle gaps that
			// land anywhere in the table walk
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
				if (gap != 0) begin
					start <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst--;
			issue(item);
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		cfg_we    <= 1'b0;
		cfg_idx   <= '0;
		cfg_wdata <= '0;
		sent      = 0;
		sweeps    = 0;
		settings  = 1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, on the reset values of the registers
		// (expire 15000, window 10000, minimum 2).
		issue(make_req(REQ_HEARTBEAT, 8'h00, 32'd100));     // id zero is ignored
		issue(make_req(REQ_SWEEP,     8'hFF, 32'd100));     // empty table
		issue(make_req(REQ_HEARTBEAT, 8'hFF, 32'd1000));    // top id inserted
		issue(make_req(REQ_HEARTBEAT, 8'h01, 32'd2000));
		issue(make_req(REQ_HEARTBEAT, 8'hFF, 32'd3000));    // refresh
		issue(make_req(REQ_SWEEP,     8'h00, 32'd3000));    // count reaches the minimum
		for (int id = 2; id <= TABLE_ENTRIES; id++)
			issue(make_req(REQ_HEARTBEAT, ID_W'(id), 32'd4000));
		issue(make_req(REQ_HEARTBEAT, 8'h80, 32'd5000));    // table full, dropped
		issue(make_req(REQ_HEARTBEAT, 8'h01, 32'd5000));    // refresh in a full table
		issue(make_req(REQ_SWEEP,     8'h00, 32'd13000));   // age exactly at window
		issue(make_req(REQ_SWEEP,     8'h00, 32'd19001));   // one past expiry evicts
		issue(make_req(REQ_HEARTBEAT, 8'h7F, 32'hFFFF_FFF0));
		issue(make_req(REQ_HEARTBEAT, 8'h01, 32'hFFFF_FFFF));
		issue(make_req(REQ_SWEEP,     8'h00, 32'h0000_0005)); // ages across the wrap
		issue(make_req(REQ_SWEEP,     8'h00, 32'hFFFF_FFF8)); // stamp ahead of now

		// Random part: defaults written back, both extremes, a window wider
		// than expiry near the wrap point, an unreachable minimum with a
		// write to the unused index, and a half-range split.
		run_phase(32'd15000, 32'd10000, 4'd2, 32'd2000, $urandom(), 190, 1'b0);
		run_phase(32'd0, 32'd0, 4'd0, 32'd2, $urandom(), 190, 1'b0);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd12, 32'hFFFF_FFFF, $urandom(), 190, 1'b0);
		run_phase(32'd600, 32'd2500, 4'd5, 32'd300, 32'hFFFF_F000, 190, 1'b0);
		run_phase($urandom_range(2000, 40000), $urandom_range(0, 40000), 4'd15, 32'd3000,
			$urandom(), 190, 1'b1);
		run_phase(32'd3000, 32'd1000, 4'd1, 32'd800, $urandom(), 190, 1'b1);
		run_phase(32'h8000_0000, 32'h7FFF_FFFF, 4'd8, 32'hFFFF_FFFF, $urandom(), 190, 1'b0);
		settle();

		$display("Covered %0d requests (%0d sweeps) across %0d table settings.",
			sent, sweeps, settings);
		$display("Compared %0d results; %0d heartbeats hit a full table; %0d mismatches.",
			checked, drops, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
sv/ppt_pkg.sv
sv/ppt_ram.sv
sv/ppt_ctrl.sv
sv/peer_presence_table.sv
test/ppt_table_check.sv
test/tb_peer_presence_table.sv
